// File: rtl/core/rgpf_pkg.sv
// ----------------------------------------------------------------------------
// rgpf_pkg: shared types, codes and helpers of the frame peak finder
// Holds the result status codes, channel codes, the result record and the
// small-float to single-precision conversion.
// ----------------------------------------------------------------------------
package rgpf_pkg;

  // largest supported frame width and height
  localparam int unsigned MaxExtent = 16384;

  // configuration port address width (two 32-bit registers)
  localparam int unsigned PaddrWidth = 3;

  localparam int unsigned PosWidth = 14;

  typedef enum logic [1:0] {
    StatusOk       = 2'd0,
    StatusBadPixel = 2'd1,
    StatusBadView  = 2'd2
  } status_e;

  localparam logic [1:0] ChanRed   = 2'd0;
  localparam logic [1:0] ChanGreen = 2'd1;
  localparam logic [1:0] ChanBlue  = 2'd2;

  typedef struct packed {
    status_e               status;
    logic [PosWidth-1:0]   peak_x;
    logic [PosWidth-1:0]   peak_y;
    logic [1:0]            peak_channel;
    logic [31:0]           red_bits;
    logic [31:0]           green_bits;
    logic [31:0]           blue_bits;
  } rgpf_result_t;

  // 11-bit unsigned small float (5-bit exponent, 6-bit mantissa, bias 15)
  // to single precision; a 10-bit blue code shifted left by one has the same value
  function automatic logic [31:0] f32_from_code(input logic [10:0] code);
    logic [4:0]  e;
    logic [5:0]  m;
    logic [2:0]  p;
    logic [28:0] sh;
    e  = code[10:6];
    m  = code[5:0];
    p  = '0;
    for (int i = 0; i < 6; i++) begin
      if (m[i]) begin
        p = 3'(i);
      end
    end
    // leading one lands on bit 23 and drops out of the fraction
    sh = 29'(m) << (5'd23 - 5'(p));
    if (e != 5'd0) begin
      return {1'b0, 8'(e) + 8'd112, m, 17'b0};
    end else if (m == 6'd0) begin
      return 32'd0;
    end else begin
      return {1'b0, 8'(p) + 8'd107, sh[22:0]};
    end
  endfunction

endpackage

// File: rtl/core/rgpf_regs.sv
// ----------------------------------------------------------------------------
// rgpf_regs: configuration registers
// APB-style register file holding the frame width and height.
// ----------------------------------------------------------------------------
module rgpf_regs (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [rgpf_pkg::PaddrWidth-1:0]  paddr,
  input  logic [31:0]                      pwdata,
  output logic [31:0]                      prdata,
  output logic                             pready,
  output logic [15:0]                      image_width_o,
  output logic [15:0]                      image_height_o
);
  import rgpf_pkg::*;

  localparam logic RegWidth  = 1'b0;
  localparam logic RegHeight = 1'b1;

  logic [15:0] width_q, width_d;
  logic [15:0] height_q, height_d;
  logic        wr_en;
  logic        reg_sel;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite && pready;
  assign reg_sel = paddr[2];

  always_comb begin
    width_d  = width_q;
    height_d = height_q;
    if (wr_en) begin
      case (reg_sel)
        RegWidth:  width_d  = pwdata[15:0];
        RegHeight: height_d = pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      RegWidth:  prdata = {16'd0, width_q};
      RegHeight: prdata = {16'd0, height_q};
      default:   prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= 16'd1;
      height_q <= 16'd1;
    end else begin
      width_q  <= width_d;
      height_q <= height_d;
    end
  end

  assign image_width_o  = width_q;
  assign image_height_o = height_q;

endmodule

// File: rtl/core/rgpf_peak.sv
// ----------------------------------------------------------------------------
// rgpf_peak: frame position and running peak tracker
// Checks the view, decodes one pixel, updates the running maximum and the
// raster position, and forms the end-of-frame result.
// ----------------------------------------------------------------------------
module rgpf_peak (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   step_i,
  input  logic [31:0]            word_i,
  input  logic [15:0]            image_width_i,
  input  logic [15:0]            image_height_i,
  output logic                   res_gen_o,
  output rgpf_pkg::rgpf_result_t res_o
);
  import rgpf_pkg::*;

  logic [PosWidth-1:0] col_q, col_d;
  logic [PosWidth-1:0] row_q, row_d;
  logic                have_q, have_d;
  logic [10:0]         key_q, key_d;
  logic [31:0]         word_q, word_d;
  logic [PosWidth-1:0] pcol_q, pcol_d;
  logic [PosWidth-1:0] prow_q, prow_d;
  logic [1:0]          chan_q, chan_d;
  logic                err_q, err_d;

  logic        view_ok;
  logic        bad_pixel;
  logic        row_end;
  logic        frame_end;
  logic [10:0] keys [3];

  assign view_ok = (image_width_i != 16'd0) && (image_height_i != 16'd0) &&
                   ({1'b0, image_width_i} <= 17'(MaxExtent)) &&
                   ({1'b0, image_height_i} <= 17'(MaxExtent));

  assign keys[0] = word_i[10:0];
  assign keys[1] = word_i[21:11];
  assign keys[2] = {word_i[31:22], 1'b0};

  assign bad_pixel = (word_i[10:6] == 5'h1f) || (word_i[21:17] == 5'h1f) ||
                     (word_i[31:27] == 5'h1f);

  assign row_end   = (16'(col_q) + 16'd1) >= image_width_i;
  assign frame_end = row_end && ((16'(row_q) + 16'd1) >= image_height_i);

  // peak update, red then green then blue, strict greater keeps the first
  always_comb begin
    have_d = have_q;
    key_d  = key_q;
    word_d = word_q;
    pcol_d = pcol_q;
    prow_d = prow_q;
    chan_d = chan_q;
    err_d  = err_q;
    if (!err_q) begin
      if (bad_pixel) begin
        err_d = 1'b1;
      end else begin
        for (int c = 0; c < 3; c++) begin
          if (!have_d || keys[c] > key_d) begin
            have_d = 1'b1;
            key_d  = keys[c];
            word_d = word_i;
            pcol_d = col_q;
            prow_d = row_q;
            chan_d = 2'(c);
          end
        end
      end
    end
  end

  always_comb begin
    if (row_end) begin
      col_d = '0;
      row_d = row_q + PosWidth'(1);
    end else begin
      col_d = col_q + PosWidth'(1);
      row_d = row_q;
    end
  end

  assign res_gen_o = !view_ok || frame_end;

  always_comb begin
    res_o = '0;
    if (!view_ok) begin
      res_o.status = StatusBadView;
    end else if (err_d) begin
      res_o.status = StatusBadPixel;
    end else begin
      res_o.status       = StatusOk;
      res_o.peak_x       = pcol_d;
      res_o.peak_y       = prow_d;
      res_o.peak_channel = chan_d;
      res_o.red_bits     = f32_from_code(word_d[10:0]);
      res_o.green_bits   = f32_from_code(word_d[21:11]);
      res_o.blue_bits    = f32_from_code({word_d[31:22], 1'b0});
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q  <= '0;
      row_q  <= '0;
      have_q <= 1'b0;
      key_q  <= '0;
      word_q <= '0;
      pcol_q <= '0;
      prow_q <= '0;
      chan_q <= ChanRed;
      err_q  <= 1'b0;
    end else if (step_i && view_ok) begin
      if (frame_end) begin
        col_q  <= '0;
        row_q  <= '0;
        have_q <= 1'b0;
        key_q  <= '0;
        word_q <= '0;
        pcol_q <= '0;
        prow_q <= '0;
        chan_q <= ChanRed;
        err_q  <= 1'b0;
      end else begin
        col_q  <= col_d;
        row_q  <= row_d;
        have_q <= have_d;
        key_q  <= key_d;
        word_q <= word_d;
        pcol_q <= pcol_d;
        prow_q <= prow_d;
        chan_q <= chan_d;
        err_q  <= err_d;
      end
    end
  end

endmodule

// File: rtl/core/rg11b10_frame_peak_finder_top.sv
// ----------------------------------------------------------------------------
// rg11b10_frame_peak_finder_top: streaming peak finder over R11G11B10 frames
// Takes packed unsigned-float pixels in raster order and reports the largest
// component of each frame with its position and decoded channels.
// ----------------------------------------------------------------------------
// One pixel is taken per clock cycle while the input is not stalled. A pixel is
// registered on transfer and is folded into the running peak and raster
// position when it steps out of the input register; a result it causes (last
// pixel of a frame, or any pixel under a bad view setting) is loaded into the
// result register at the end of that step. The only limit on rate is the single
// result register: the input stalls only while a pending pixel would produce a
// result and the result register is still held by a stalled output.
// A width or height of zero or above 16384 answers every pixel with an
// invalid-view result and leaves the frame state alone. Change the size
// registers only while the block is idle.
module rg11b10_frame_peak_finder_top (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [rgpf_pkg::PaddrWidth-1:0]  paddr,
  input  logic [31:0]                      pwdata,
  output logic [31:0]                      prdata,
  output logic                             pready,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic [31:0]                      pixel_word_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic [1:0]                       status_o,
  output logic [13:0]                      peak_x_o,
  output logic [13:0]                      peak_y_o,
  output logic [1:0]                       peak_channel_o,
  output logic [31:0]                      peak_red_bits_o,
  output logic [31:0]                      peak_green_bits_o,
  output logic [31:0]                      peak_blue_bits_o
);
  import rgpf_pkg::*;

  logic [15:0]  image_width;
  logic [15:0]  image_height;

  logic         s1_valid_q, s1_valid_d;
  logic [31:0]  s1_word_q;
  logic         in_xfer;
  logic         step;
  logic         res_gen;
  logic         out_free;
  rgpf_result_t res;
  rgpf_result_t out_q;
  logic         out_valid_q, out_valid_d;

  rgpf_regs u_regs (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready),
    .image_width_o  (image_width),
    .image_height_o (image_height)
  );

  rgpf_peak u_peak (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .step_i         (step),
    .word_i         (s1_word_q),
    .image_width_i  (image_width),
    .image_height_i (image_height),
    .res_gen_o      (res_gen),
    .res_o          (res)
  );

  assign out_free   = !out_valid_q || !out_stall_i;
  assign step       = s1_valid_q && (!res_gen || out_free);
  assign in_stall_o = s1_valid_q && !step;
  assign in_xfer    = in_valid_i && !in_stall_o;

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (in_xfer) begin
      s1_valid_d = 1'b1;
    end else if (step) begin
      s1_valid_d = 1'b0;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (step && res_gen) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      s1_word_q <= pixel_word_i;
    end
    if (step && res_gen) begin
      out_q <= res;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign status_o          = out_q.status;
  assign peak_x_o          = out_q.peak_x;
  assign peak_y_o          = out_q.peak_y;
  assign peak_channel_o    = out_q.peak_channel;
  assign peak_red_bits_o   = out_q.red_bits;
  assign peak_green_bits_o = out_q.green_bits;
  assign peak_blue_bits_o  = out_q.blue_bits;

`ifndef NO_ASSERTIONS
  // a stall is only raised while a pixel is pending in the input register
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> s1_valid_q)
    else $error("input stalled with no pending pixel");

  // a new result never overwrites one that is still being held
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step && res_gen) |-> out_free)
    else $error("result register overwritten while held");

  // a pixel held back stays pending into the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && !step) |=> s1_valid_q)
    else $error("pending pixel dropped");

  // an ok result always names a real channel
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && status_o == StatusOk) |-> (peak_channel_o != 2'd3))
    else $error("ok result with bad channel code");
`endif

endmodule

// File: sim/rg11b10_frame_peak_finder_top_tb.sv
// ----------------------------------------------------------------------------
// rg11b10_frame_peak_finder_top_tb: self-checking bench for the frame peak finder
// Streams packed pixels through the block under random source gaps and sink
// stalls. It predicts each frame's peak, or error result, from its own model of
// the decoder and compares every result transfer field by field.
// ----------------------------------------------------------------------------
module rg11b10_frame_peak_finder_top_tb;
  import rgpf_pkg::*;

  localparam int unsigned RegWidth   = 0;
  localparam int unsigned RegHeight  = 1;
  localparam int unsigned CycleLimit = 1000000;
  localparam int unsigned HoldCycles = 300;
  localparam int unsigned MaxReports = 10;

  typedef struct {
    logic [31:0] word;
    int unsigned gap;
  } px_item_t;

  logic        clk_i;
  logic        rst_ni = 1'b0;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [PaddrWidth-1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [31:0] pixel_word_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [1:0]  status_o;
  logic [13:0] peak_x_o;
  logic [13:0] peak_y_o;
  logic [1:0]  peak_channel_o;
  logic [31:0] peak_red_bits_o;
  logic [31:0] peak_green_bits_o;
  logic [31:0] peak_blue_bits_o;

  rg11b10_frame_peak_finder_top i_dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .psel              (psel),
    .penable           (penable),
    .pwrite            (pwrite),
    .paddr             (paddr),
    .pwdata            (pwdata),
    .prdata            (prdata),
    .pready            (pready),
    .in_valid_i        (in_valid_i),
    .in_stall_o        (in_stall_o),
    .pixel_word_i      (pixel_word_i),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .status_o          (status_o),
    .peak_x_o          (peak_x_o),
    .peak_y_o          (peak_y_o),
    .peak_channel_o    (peak_channel_o),
    .peak_red_bits_o   (peak_red_bits_o),
    .peak_green_bits_o (peak_green_bits_o),
    .peak_blue_bits_o  (peak_blue_bits_o)
  );

  // pending pixels and predicted frame results
  px_item_t     pending_px_q[$];
  rgpf_result_t frame_result_q[$];

  // copy of the size registers
  logic [15:0] view_width  = 16'd1;
  logic [15:0] view_height = 16'd1;

  // running frame state of the predictor
  logic [13:0] px_col = '0;
  logic [13:0] px_row = '0;
  logic        best_valid = 1'b0;
  logic [10:0] best_key = '0;
  logic [31:0] best_word = '0;
  logic [13:0] best_col = '0;
  logic [13:0] best_row = '0;
  logic [1:0]  best_chan = '0;
  logic        bad_px_seen = 1'b0;

  logic        px_xfer = 1'b0;
  logic        res_xfer = 1'b0;
  int unsigned px_gap_cnt = 0;
  int unsigned rx_gap_max = 12;
  int unsigned rx_wait = 0;
  int unsigned hold_req = 0;
  int unsigned hold_seen = 0;
  int unsigned hold_left = 0;
  int unsigned cycle_cnt = 0;
  int unsigned fail_cnt = 0;
  int unsigned n_px = 0;
  int unsigned n_ok = 0;
  int unsigned n_bad_px = 0;
  int unsigned n_bad_view = 0;

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // exact single-precision pattern of an unsigned small float
  function automatic logic [31:0] small_to_single(input logic [10:0] code,
                                                  input int unsigned mbits);
    logic [4:0]  ex;
    logic [31:0] man;
    int unsigned lead;
    ex   = 5'(code >> mbits);
    man  = 32'(code) & ((32'd1 << mbits) - 32'd1);
    lead = 0;
    if (ex != 5'd0) begin
      return {1'b0, 8'(ex) + 8'd112, 23'(man << (23 - mbits))};
    end
    if (man == 32'd0) begin
      return 32'd0;
    end
    for (int i = 0; i < 6; i++) begin
      if (man[i]) begin
        lead = i;
      end
    end
    return {1'b0, 8'(lead + 113 - mbits), 23'((man ^ (32'd1 << lead)) << (23 - lead))};
  endfunction

  task automatic fold_pixel(input logic [31:0] word);
    logic [10:0]  key [3];
    logic [1:0]   chan_code [3];
    rgpf_result_t res;
    logic         row_end;
    logic         frame_end;
    chan_code[0] = ChanRed;
    chan_code[1] = ChanGreen;
    chan_code[2] = ChanBlue;
    res = '0;
    n_px++;
    if (view_width == 16'd0 || view_height == 16'd0 ||
        view_width > MaxExtent || view_height > MaxExtent) begin
      res.status = StatusBadView;
      frame_result_q.push_back(res);
      n_bad_view++;
      return;
    end
    if (!bad_px_seen) begin
      if (word[10:6] == 5'h1f || word[21:17] == 5'h1f || word[31:27] == 5'h1f) begin
        bad_px_seen = 1'b1;
      end else begin
        key[0] = word[10:0];
        key[1] = word[21:11];
        key[2] = {word[31:22], 1'b0};
        // strict compare keeps the first of equal components
        for (int c = 0; c < 3; c++) begin
          if (!best_valid || key[c] > best_key) begin
            best_valid = 1'b1;
            best_key   = key[c];
            best_word  = word;
            best_col   = px_col;
            best_row   = px_row;
            best_chan  = chan_code[c];
          end
        end
      end
    end
    row_end   = (32'(px_col) + 32'd1) >= 32'(view_width);
    frame_end = row_end && ((32'(px_row) + 32'd1) >= 32'(view_height));
    if (!frame_end) begin
      if (row_end) begin
        px_col = '0;
        px_row = px_row + 14'd1;
      end else begin
        px_col = px_col + 14'd1;
      end
      return;
    end
    if (bad_px_seen) begin
      res.status = StatusBadPixel;
      n_bad_px++;
    end else begin
      res.status       = StatusOk;
      res.peak_x       = best_col;
      res.peak_y       = best_row;
      res.peak_channel = best_chan;
      res.red_bits     = small_to_single(best_word[10:0], 6);
      res.green_bits   = small_to_single(best_word[21:11], 6);
      res.blue_bits    = small_to_single({1'b0, best_word[31:22]}, 5);
      n_ok++;
    end
    frame_result_q.push_back(res);
    px_col      = '0;
    px_row      = '0;
    best_valid  = 1'b0;
    best_key    = '0;
    best_word   = '0;
    best_col    = '0;
    best_row    = '0;
    best_chan   = '0;
    bad_px_seen = 1'b0;
  endtask

  // monitor: results are checked before the same edge's pixel is folded in
  always @(posedge clk_i) begin : monitor
    rgpf_result_t got;
    rgpf_result_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      got = '{status_e'(status_o), peak_x_o, peak_y_o, peak_channel_o,
              peak_red_bits_o, peak_green_bits_o, peak_blue_bits_o};
      if (frame_result_q.size() == 0) begin
        fail_cnt++;
        if (fail_cnt <= MaxReports) begin
          $display("unexpected result transfer: status %0d x %0d y %0d", status_o,
                   peak_x_o, peak_y_o);
        end
      end else begin
        want = frame_result_q.pop_front();
        if (got.status !== want.status || got.peak_x !== want.peak_x ||
            got.peak_y !== want.peak_y || got.peak_channel !== want.peak_channel ||
            got.red_bits !== want.red_bits || got.green_bits !== want.green_bits ||
            got.blue_bits !== want.blue_bits) begin
          fail_cnt++;
          if (fail_cnt <= MaxReports) begin
            $display("result mismatch: expected st %0d x %0d y %0d ch %0d r %h g %h b %h",
                     want.status, want.peak_x, want.peak_y, want.peak_channel,
                     want.red_bits, want.green_bits, want.blue_bits);
            $display("                 actual   st %0d x %0d y %0d ch %0d r %h g %h b %h",
                     got.status, got.peak_x, got.peak_y, got.peak_channel,
                     got.red_bits, got.green_bits, got.blue_bits);
          end
        end
      end
    end
    if (rst_ni && in_valid_i && !in_stall_o) begin
      fold_pixel(pixel_word_i);
    end
    px_xfer  <= rst_ni && in_valid_i && !in_stall_o;
    res_xfer <= rst_ni && out_valid_o && !out_stall_i;
  end

  // pixel driver
  always @(negedge clk_i) begin : drive_px
    logic        nxt_valid;
    logic [31:0] nxt_word;
    px_item_t    item;
    nxt_valid = in_valid_i;
    nxt_word  = pixel_word_i;
    if (in_valid_i && px_xfer) begin
      nxt_valid = 1'b0;
    end
    if (rst_ni && !nxt_valid && pending_px_q.size() != 0) begin
      if (px_gap_cnt < pending_px_q[0].gap) begin
        px_gap_cnt++;
      end else begin
        item       = pending_px_q.pop_front();
        px_gap_cnt = 0;
        nxt_valid  = 1'b1;
        nxt_word   = item.word;
      end
    end
    in_valid_i   <= nxt_valid;
    pixel_word_i <= nxt_word;
  end

  // result sink: a random wait after each transfer, plus the long hold-off
  always @(negedge clk_i) begin : drive_sink
    if (hold_seen != hold_req) begin
      hold_seen = hold_req;
      hold_left = HoldCycles;
    end
    if (res_xfer) begin
      rx_wait = $urandom_range(0, rx_gap_max);
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall_i <= 1'b1;
    end else if (rx_wait > 0) begin
      rx_wait--;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  initial begin : watchdog
    while (cycle_cnt < CycleLimit) begin
      @(posedge clk_i);
      cycle_cnt++;
    end
    $display("FAILURE");
    $finish;
  end

  // valid code with exponent below 31
  function automatic logic [10:0] rand_code(input int unsigned mbits,
                                            input int unsigned top_ex);
    logic [4:0] ex;
    logic [5:0] mn;
    case ($urandom_range(0, 7))
      0: begin
        ex = 5'd0;
      end
      1: begin
        ex = 5'(top_ex);
      end
      default: begin
        ex = 5'($urandom_range(0, top_ex));
      end
    endcase
    mn = 6'($urandom);
    if ($urandom_range(0, 9) == 0) begin
      mn = 6'd0;
    end
    return (mbits == 6) ? {ex, mn} : {1'b0, ex, mn[4:0]};
  endfunction

  function automatic logic [31:0] rand_pixel(input bit allow_bad, input int unsigned top_ex);
    logic [10:0] r;
    logic [10:0] g;
    logic [10:0] b;
    int unsigned pick;
    r    = rand_code(6, top_ex);
    g    = rand_code(6, top_ex);
    b    = rand_code(5, top_ex);
    pick = $urandom_range(0, 99);
    if (pick < 8) begin
      // equal keys in all three channels
      r[0] = 1'b0;
      g    = r;
      b    = {1'b0, r[10:1]};
    end else if (pick < 14) begin
      g = r;
    end
    if (allow_bad) begin
      case ($urandom_range(0, 199))
        0: r[10:6] = 5'h1f;
        1: g[10:6] = 5'h1f;
        2: b[9:5]  = 5'h1f;
        3, 4: return $urandom;
        default: ;
      endcase
    end
    return {b[9:0], g, r};
  endfunction

  task automatic push_px(input logic [31:0] word, input int unsigned gap_max);
    pending_px_q.push_back('{word, $urandom_range(0, gap_max)});
  endtask

  task automatic wait_idle();
    while (pending_px_q.size() != 0 || in_valid_i || frame_result_q.size() != 0) begin
      @(posedge clk_i);
    end
    // a pixel without a result may still be in flight
    repeat (6) @(posedge clk_i);
  endtask

  task automatic write_reg(input int unsigned idx, input logic [15:0] val);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= PaddrWidth'(idx * 4);
    pwdata  <= {16'($urandom), val};
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    @(negedge clk_i);
    pwrite  <= 1'b0;
    penable <= 1'b0;
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    if (prdata[15:0] !== val) begin
      fail_cnt++;
      if (fail_cnt <= MaxReports) begin
        $display("register %0d read back %h, expected %h", idx, prdata[15:0], val);
      end
    end
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    if (idx == RegWidth) begin
      view_width = val;
    end else begin
      view_height = val;
    end
  endtask

  task automatic set_view(input logic [15:0] w, input logic [15:0] h);
    write_reg(RegWidth, w);
    write_reg(RegHeight, h);
  endtask

  initial begin : stimulus
    logic [15:0] w;
    logic [15:0] h;
    int unsigned n;
    int unsigned px_gap;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // single-pixel frames at the reset size
    push_px(32'h0000_0000, 12);
    push_px({10'h3df, 11'h7bf, 11'h7bf}, 12);
    push_px({10'h01f, 11'h020, 11'h001}, 12);
    push_px({10'h152, 11'h2a4, 11'h2a4}, 12);
    push_px({10'h000, 11'h400, 11'h100}, 12);
    push_px({10'h000, 11'h000, 11'h040}, 12);
    push_px({10'h3e0, 11'h000, 11'h000}, 12);
    push_px({10'h000, 11'h7c0, 11'h000}, 12);
    push_px({10'h000, 11'h000, 11'h7c0}, 12);
    push_px(32'hffff_ffff, 12);
    wait_idle();
    // 2x2: bad pixel first, then a frame with the peak in its last pixel
    set_view(16'd2, 16'd2);
    push_px(32'h0000_07c0, 12);
    push_px(32'h0000_07bf, 12);
    push_px(32'h0000_0001, 12);
    push_px(32'h0000_0002, 12);
    push_px(32'h0000_0001, 12);
    push_px(32'h0000_0002, 12);
    push_px(32'h0000_0003, 12);
    push_px({10'h3df, 11'h000, 11'h000}, 12);
    wait_idle();
    set_view(16'd0, 16'd2);
    push_px(32'h1234_5678, 12);
    push_px(32'hffff_ffff, 12);
    wait_idle();

    // long sink hold-off with a result per pixel so the block backs up
    set_view(16'd1, 16'd1);
    rx_gap_max = 0;
    hold_req++;
    for (int i = 0; i < 60; i++) begin
      push_px(rand_pixel(1'b1, 30), 0);
    end
    wait_idle();

    // long row, peak in its very last pixel
    rx_gap_max = 12;
    set_view(16'd200, 16'd1);
    for (int i = 0; i < 199; i++) begin
      push_px(rand_pixel(1'b0, 29), 0);
    end
    push_px(32'h0000_07bf, 0);
    wait_idle();
    // tallest column, cut short by shrinking the height
    set_view(16'd1, 16'd16384);
    for (int i = 0; i < 40; i++) begin
      push_px(rand_pixel(1'b0, 30), 3);
    end
    wait_idle();
    set_view(16'd1, 16'd1);
    push_px(rand_pixel(1'b0, 30), 3);
    wait_idle();
    set_view(16'd16384, 16'd16384);
    for (int i = 0; i < 20; i++) begin
      push_px(rand_pixel(1'b1, 30), 3);
    end
    wait_idle();

    // random frames; phase edges fall mid-frame on purpose
    for (int ph = 0; ph < 14; ph++) begin
      w = 16'($urandom_range(1, 6));
      h = 16'($urandom_range(1, 5));
      n = 90;
      if (ph == 6) begin
        w = 16'($urandom_range(8, 40));
        h = 16'($urandom_range(1, 3));
      end
      if (ph % 5 == 3) begin
        n = 30;
        case (ph / 5)
          0: w = 16'd0;
          1: h = 16'hffff;
          default: begin
            w = 16'd16385;
            h = 16'd0;
          end
        endcase
      end
      px_gap     = (ph % 3 == 0) ? 0 : 12;
      rx_gap_max = (ph % 4 == 1) ? 0 : 12;
      set_view(w, h);
      for (int i = 0; i < n; i++) begin
        push_px(rand_pixel(1'b1, 30), px_gap);
      end
      wait_idle();
    end

    $display("run covered %0d pixels and %0d results: %0d ok, %0d bad pixel, %0d bad view",
             n_px, n_ok + n_bad_px + n_bad_view, n_ok, n_bad_px, n_bad_view);
    $display("sizes from 0 to 65535, a 200-pixel row and mid-frame shrinks");
    if (fail_cnt == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// File: sim.f
rtl/core/rgpf_pkg.sv
rtl/core/rgpf_regs.sv
rtl/core/rgpf_peak.sv
rtl/core/rg11b10_frame_peak_finder_top.sv
sim/rg11b10_frame_peak_finder_top_tb.sv
